>>> src/oats_pkg.sv
// Package for the ordered array table: operation and status codes, the cell
// control struct and default sizes. Used by the interfaces, cells, control and top.
// No dependencies.
package oats_pkg;

    localparam int CAPACITY_DEF  = 64;
    localparam int WORD_BITS_DEF = 32;

    localparam int KIND_BITS = 3;
    localparam int POS_BITS  = 7;
    localparam int STAT_BITS = 3;

    localparam logic [KIND_BITS-1:0] KIND_CLEAR  = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_APPEND = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_INSERT = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_DELETE = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_MAX    = 3'd4;
    localparam logic [KIND_BITS-1:0] KIND_SORT   = 3'd5;
    localparam logic [KIND_BITS-1:0] KIND_SEARCH = 3'd6;
    localparam logic [KIND_BITS-1:0] KIND_DUMP   = 3'd7;

    localparam logic [STAT_BITS-1:0] STAT_OK       = 3'd0;
    localparam logic [STAT_BITS-1:0] STAT_FULL     = 3'd1;
    localparam logic [STAT_BITS-1:0] STAT_BADPOS   = 3'd2;
    localparam logic [STAT_BITS-1:0] STAT_EMPTY    = 3'd3;
    localparam logic [STAT_BITS-1:0] STAT_NOTFOUND = 3'd4;

    localparam int CELL_OP_BITS = 3;
    localparam logic [CELL_OP_BITS-1:0] CELL_HOLD   = 3'd0;
    localparam logic [CELL_OP_BITS-1:0] CELL_APPEND = 3'd1;
    localparam logic [CELL_OP_BITS-1:0] CELL_INSERT = 3'd2;
    localparam logic [CELL_OP_BITS-1:0] CELL_DELETE = 3'd3;
    localparam logic [CELL_OP_BITS-1:0] CELL_ROTATE = 3'd4;
    localparam logic [CELL_OP_BITS-1:0] CELL_SORT   = 3'd5;

    typedef struct packed {
        logic [CELL_OP_BITS-1:0] op;
        logic                    phase;
    } t_cell_ctl;

endpackage

>>> src/oats_req_if.sv
// Request channel of the ordered array table: valid/ready and the request fields.
// Depends on oats_pkg.
interface oats_req_if #(
    parameter int WORD_BITS = oats_pkg::WORD_BITS_DEF
);
    logic                           valid;
    logic                           ready;
    logic [oats_pkg::KIND_BITS-1:0] kind;
    logic signed [WORD_BITS-1:0]    value;
    logic [oats_pkg::POS_BITS-1:0]  position;

    modport source (output valid, kind, value, position, input ready);
    modport sink   (input valid, kind, value, position, output ready);
endinterface

>>> src/oats_rsp_if.sv
// Response channel of the ordered array table: valid/ready and the result fields.
// Depends on oats_pkg.
interface oats_rsp_if #(
    parameter int WORD_BITS = oats_pkg::WORD_BITS_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [WORD_BITS-1:0]    result_value;
    logic [oats_pkg::POS_BITS-1:0]  result_position;
    logic [oats_pkg::STAT_BITS-1:0] status;
    logic                           last;

    modport source (output valid, result_value, result_position, status, last, input ready);
    modport sink   (input valid, result_value, result_position, status, last, output ready);
endinterface

>>> src/oats_cell.sv
// One storage cell of the table chain: holds one element and trades it with its
// neighbors for append, insert, delete, rotation and compare-exchange sorting.
// Depends on oats_pkg.
module oats_cell #(
    parameter int IDX       = 0,
    parameter int CAPACITY  = oats_pkg::CAPACITY_DEF,
    parameter int WORD_BITS = oats_pkg::WORD_BITS_DEF
) (
    input  logic                                   i_clk,
    input  oats_pkg::t_cell_ctl                    i_ctl,
    input  logic [$clog2(CAPACITY+1)-1:0]          i_count,
    input  logic [$clog2(CAPACITY+1)-1:0]          i_start,
    input  logic [WORD_BITS-1:0]                   i_value,
    input  logic [WORD_BITS-1:0]                   i_left,
    input  logic [WORD_BITS-1:0]                   i_right,
    output logic [WORD_BITS-1:0]                   o_data
);
    localparam int CNT_BITS = $clog2(CAPACITY+1);
    localparam logic [CNT_BITS-1:0] IDX_W    = CNT_BITS'(IDX);
    localparam logic [CNT_BITS-1:0] IDX_NEXT = CNT_BITS'(IDX + 1);
    localparam logic IDX_ODD  = 1'(IDX % 2);
    localparam logic HAS_LEFT = (IDX > 0);

    logic [WORD_BITS-1:0] r_data;
    logic [WORD_BITS-1:0] n_data;
    logic                 lower;
    logic                 upper;

    // In a sort phase a cell is either the low or the high end of a pair.
    assign lower = (IDX_ODD == i_ctl.phase) && (IDX_NEXT < i_count);
    assign upper = (IDX_ODD != i_ctl.phase) && HAS_LEFT && (IDX_W < i_count);

    always_comb begin
        n_data = r_data;
        unique case (i_ctl.op)
            oats_pkg::CELL_HOLD: begin
                n_data = r_data;
            end
            oats_pkg::CELL_APPEND: begin
                if (i_count == IDX_W) n_data = i_value;
            end
            oats_pkg::CELL_INSERT: begin
                if (IDX_W == i_start) begin
                    n_data = i_value;
                end else if (IDX_W > i_start) begin
                    n_data = i_left;
                end
            end
            oats_pkg::CELL_DELETE: begin
                if (IDX_W >= i_start) n_data = i_right;
            end
            oats_pkg::CELL_ROTATE: begin
                n_data = i_right;
            end
            oats_pkg::CELL_SORT: begin
                if (lower && ($signed(r_data) > $signed(i_right))) begin
                    n_data = i_right;
                end else if (upper && ($signed(i_left) > $signed(r_data))) begin
                    n_data = i_left;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

>>> src/oats_ctrl.sv
// Sequencer of the ordered array table: request decoding, element count, the
// rotation walk for max/search/dump, the sort phases and the response register.
// Depends on oats_pkg, oats_req_if and oats_rsp_if.
module oats_ctrl #(
    parameter int CAPACITY  = oats_pkg::CAPACITY_DEF,
    parameter int WORD_BITS = oats_pkg::WORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    oats_req_if.sink                          i_req,
    oats_rsp_if.source                        o_rsp,
    input  logic [WORD_BITS-1:0]              i_head,
    output oats_pkg::t_cell_ctl               o_ctl,
    output logic [$clog2(CAPACITY+1)-1:0]     o_count,
    output logic [$clog2(CAPACITY+1)-1:0]     o_start,
    output logic [WORD_BITS-1:0]              o_value
);
    localparam int CNT_BITS  = $clog2(CAPACITY+1);
    localparam int STEP_BITS = $clog2(CAPACITY);
    localparam int CW = ((oats_pkg::POS_BITS > CNT_BITS) ? oats_pkg::POS_BITS : CNT_BITS) + 1;
    localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(CAPACITY - 1);
    localparam logic [CNT_BITS-1:0]  CNT_FULL  = CNT_BITS'(CAPACITY);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;
    localparam logic [1:0] ST_SORT = 2'd3;

    logic [1:0]                         r_state, n_state;
    logic [CNT_BITS-1:0]                r_count, n_count;
    logic [STEP_BITS-1:0]               r_step, n_step;
    logic [oats_pkg::KIND_BITS-1:0]     r_kind, n_kind;
    logic [WORD_BITS-1:0]               r_key, n_key;
    logic [WORD_BITS-1:0]               r_best, n_best;
    logic                               r_hit, n_hit;
    logic [STEP_BITS-1:0]               r_hit_idx, n_hit_idx;
    logic                               r_phase, n_phase;

    logic                               r_ovalid;
    logic [WORD_BITS-1:0]               r_oval;
    logic [oats_pkg::POS_BITS-1:0]      r_opos;
    logic [oats_pkg::STAT_BITS-1:0]     r_ostat;
    logic                               r_olast;

    logic                               out_free;
    logic                               acc;
    logic                               need_emit;
    logic                               emit;
    logic                               advance;
    logic [WORD_BITS-1:0]               e_val;
    logic [oats_pkg::POS_BITS-1:0]      e_pos;
    logic [oats_pkg::STAT_BITS-1:0]     e_stat;
    logic                               e_last;
    logic [CW-1:0]                      pos_w;
    logic [CW-1:0]                      cnt_w;
    logic                               full;
    logic                               empty;
    logic                               ins_bad;
    logic                               del_bad;
    logic                               in_use;
    logic                               match;
    logic [CNT_BITS-1:0]                head_pos;
    logic [CNT_BITS-1:0]                hit_pos;

    assign out_free = !r_ovalid || o_rsp.ready;
    assign i_req.ready = (r_state == ST_IDLE) && out_free;
    assign acc = i_req.valid && i_req.ready;

    assign pos_w   = CW'(i_req.position);
    assign cnt_w   = CW'(r_count);
    assign full    = (r_count == CNT_FULL);
    assign empty   = (r_count == '0);
    assign ins_bad = (pos_w == '0) || (pos_w > cnt_w + CW'(1));
    assign del_bad = (pos_w == '0) || (pos_w > cnt_w);

    assign in_use   = CNT_BITS'(r_step) < r_count;
    assign head_pos = CNT_BITS'(r_step) + CNT_BITS'(1);
    assign hit_pos  = CNT_BITS'(r_hit_idx) + CNT_BITS'(1);
    assign match    = in_use && (i_head == r_key);

    assign o_count = r_count;
    assign o_start = CNT_BITS'(pos_w - CW'(1));
    assign o_value = i_req.value;
    assign emit    = need_emit && out_free;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_step    = r_step;
        n_kind    = r_kind;
        n_key     = r_key;
        n_best    = r_best;
        n_hit     = r_hit;
        n_hit_idx = r_hit_idx;
        n_phase   = r_phase;
        o_ctl.op    = oats_pkg::CELL_HOLD;
        o_ctl.phase = r_phase;
        need_emit = 1'b0;
        advance   = 1'b0;
        e_val     = '0;
        e_pos     = '0;
        e_stat    = oats_pkg::STAT_OK;
        e_last    = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    n_kind = i_req.kind;
                    n_key  = i_req.value;
                    n_step = '0;
                    n_hit  = 1'b0;
                    unique case (i_req.kind)
                        oats_pkg::KIND_CLEAR: begin
                            need_emit = 1'b1;
                            n_count   = '0;
                        end
                        oats_pkg::KIND_APPEND: begin
                            need_emit = 1'b1;
                            if (full) begin
                                e_stat = oats_pkg::STAT_FULL;
                            end else begin
                                o_ctl.op = oats_pkg::CELL_APPEND;
                                n_count  = r_count + CNT_BITS'(1);
                            end
                        end
                        oats_pkg::KIND_INSERT: begin
                            need_emit = 1'b1;
                            if (full) begin
                                e_stat = oats_pkg::STAT_FULL;
                            end else if (ins_bad) begin
                                e_stat = oats_pkg::STAT_BADPOS;
                            end else begin
                                o_ctl.op = oats_pkg::CELL_INSERT;
                                n_count  = r_count + CNT_BITS'(1);
                            end
                        end
                        oats_pkg::KIND_DELETE: begin
                            need_emit = 1'b1;
                            if (empty) begin
                                e_stat = oats_pkg::STAT_EMPTY;
                            end else if (del_bad) begin
                                e_stat = oats_pkg::STAT_BADPOS;
                            end else begin
                                o_ctl.op = oats_pkg::CELL_DELETE;
                                n_count  = r_count - CNT_BITS'(1);
                            end
                        end
                        oats_pkg::KIND_MAX, oats_pkg::KIND_DUMP: begin
                            if (empty) begin
                                need_emit = 1'b1;
                                e_stat    = oats_pkg::STAT_EMPTY;
                            end else begin
                                n_state = ST_WALK;
                            end
                        end
                        oats_pkg::KIND_SORT: begin
                            // The response goes out now; the sort phases follow
                            // before the next request is taken.
                            need_emit = 1'b1;
                            n_state   = ST_SORT;
                            n_phase   = 1'b0;
                        end
                        oats_pkg::KIND_SEARCH: begin
                            n_state = ST_WALK;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                // After r_step rotations the head cell holds element r_step.
                priority if (r_kind == oats_pkg::KIND_MAX) begin
                    if ((r_step == '0) || (in_use && ($signed(i_head) > $signed(r_best)))) begin
                        n_best = i_head;
                    end
                end else if (r_kind == oats_pkg::KIND_SEARCH) begin
                    // A match is held back until the next one is found so that the final one can carry last.
                    if (match && r_hit) begin
                        need_emit = 1'b1;
                        e_val     = r_key;
                        e_pos     = oats_pkg::POS_BITS'(hit_pos);
                        e_last    = 1'b0;
                    end
                    if (match && (!r_hit || out_free)) begin
                        n_hit     = 1'b1;
                        n_hit_idx = r_step;
                    end
                end else begin
                    if (in_use) begin
                        need_emit = 1'b1;
                        e_val     = i_head;
                        e_pos     = oats_pkg::POS_BITS'(head_pos);
                        e_last    = (head_pos == r_count);
                    end
                end
                advance = !need_emit || out_free;
                if (advance) begin
                    o_ctl.op = oats_pkg::CELL_ROTATE;
                    n_step   = r_step + STEP_BITS'(1);
                    if (r_step == STEP_LAST) begin
                        n_state = (r_kind == oats_pkg::KIND_DUMP) ? ST_IDLE : ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                need_emit = 1'b1;
                if (r_kind == oats_pkg::KIND_MAX) begin
                    e_val = r_best;
                end else begin
                    e_val = r_key;
                    if (r_hit) begin
                        e_pos = oats_pkg::POS_BITS'(hit_pos);
                    end else begin
                        e_stat = oats_pkg::STAT_NOTFOUND;
                    end
                end
                if (out_free) n_state = ST_IDLE;
            end
            ST_SORT: begin
                o_ctl.op = oats_pkg::CELL_SORT;
                n_phase  = !r_phase;
                n_step   = r_step + STEP_BITS'(1);
                if (r_step == STEP_LAST) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_step   <= '0;
            r_hit    <= 1'b0;
            r_phase  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_step  <= n_step;
            r_hit   <= n_hit;
            r_phase <= n_phase;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_key     <= n_key;
        r_best    <= n_best;
        r_hit_idx <= n_hit_idx;
        if (emit) begin
            r_oval  <= e_val;
            r_opos  <= e_pos;
            r_ostat <= e_stat;
            r_olast <= e_last;
        end
    end

    assign o_rsp.valid           = r_ovalid;
    assign o_rsp.result_value    = r_oval;
    assign o_rsp.result_position = r_opos;
    assign o_rsp.status          = r_ostat;
    assign o_rsp.last            = r_olast;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("element count above capacity");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        need_emit && !out_free |=> r_ovalid && $stable(r_oval) && $stable(r_olast))
        else $error("pending response overwritten");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && (i_req.kind == oats_pkg::KIND_APPEND) && !full
        |=> r_count == $past(r_count) + CNT_BITS'(1))
        else $error("append did not grow the table");

    a_walk_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) && !advance |=> $stable(r_step) && (r_state == ST_WALK))
        else $error("walk moved while the response was stalled");

endmodule

>>> src/ordered_array_table_with_sort_core.sv
// Ordered array table with sort: request and response channels over valid/ready.
// Requests: clear, append, insert, delete, max, sort, search, dump.
// Each request gives one or more responses; the final one carries last.
// Clear, append, insert and delete update the table as they are accepted.
// Sort gives its response at once and then runs CAPACITY compare-exchange phases
// across the cell chain (odd-even transposition), one per cycle; no request is
// taken meanwhile.
// Max, search and dump rotate the whole chain once through its head cell, one
// element per cycle while no response stalls; max and search then give the final
// response from a finish state.
// A dump or search response that is not taken stops the rotation until it is.
// Responses sit in an output register and are valid the cycle after they are
// formed; for clear, append, insert, delete and sort that is the cycle after accept.
// A new request is accepted while a finished response waits, as long as the
// block is between requests and the register is taken or empty in that cycle.
// Reset (synchronous, active low) empties the table and drops any pending response;
// element contents are not cleared.
// Depends on oats_pkg, oats_req_if, oats_rsp_if, oats_cell and oats_ctrl.
module ordered_array_table_with_sort_core #(
    parameter int CAPACITY  = oats_pkg::CAPACITY_DEF,
    parameter int WORD_BITS = oats_pkg::WORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    oats_req_if.sink    i_req,
    oats_rsp_if.source  o_rsp
);
    localparam int CNT_BITS = $clog2(CAPACITY+1);

    oats_pkg::t_cell_ctl        w_ctl;
    logic [CNT_BITS-1:0]        w_count;
    logic [CNT_BITS-1:0]        w_start;
    logic [WORD_BITS-1:0]       w_value;
    logic [WORD_BITS-1:0]       w_data [CAPACITY];

    oats_ctrl #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_head  (w_data[0]),
        .o_ctl   (w_ctl),
        .o_count (w_count),
        .o_start (w_start),
        .o_value (w_value)
    );

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [WORD_BITS-1:0] w_left;
        logic [WORD_BITS-1:0] w_right;

        // The chain closes into a ring so that a full rotation restores the order.
        if (g == 0) begin : g_first
            assign w_left = w_data[0];
        end else begin : g_mid
            assign w_left = w_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_wrap
            assign w_right = w_data[0];
        end else begin : g_next
            assign w_right = w_data[g+1];
        end

        oats_cell #(
            .IDX       (g),
            .CAPACITY  (CAPACITY),
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_count (w_count),
            .i_start (w_start),
            .i_value (w_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[g])
        );
    end

endmodule
